/* src/sbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

	// Coefficient and register formats
	localparam int COEF_W     = 30;
	localparam int A1_W       = 28;
	localparam int A2_W       = 27;
	localparam int GAIN_W     = 16;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int COEF_FRAC  = 26;
	localparam int GAIN_SHIFT = 15;

	// Default widths of samples and internal values
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int STATE_WIDTH_DEF  = 32;

	// Section sequencing
	localparam int NSEC   = 8;
	localparam int SEC_W  = 3;
	localparam int STEP_W = 3;

	localparam logic [SEC_W-1:0] SEC_LAST  = SEC_W'(NSEC - 1);
	localparam logic [SEC_W-1:0] SEC_LP2_L = 3'd1;
	localparam logic [SEC_W-1:0] SEC_HP2_L = 3'd3;
	localparam logic [SEC_W-1:0] SEC_LP2_R = 3'd5;
	localparam logic [SEC_W-1:0] SEC_HP2_R = 3'd7;

	// Steps inside one section: five products, then finish
	localparam logic [STEP_W-1:0] STEP_X0  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_X1  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_X2  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_Y1  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_Y2  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_FIN = 3'd5;

	// Clamp limits and reset values
	localparam logic signed [COEF_W-1:0] B0_MAX = 30'sd335544320;
	localparam logic signed [COEF_W-1:0] B0_MIN = -30'sd335544320;
	localparam logic signed [A1_W-1:0]   A1_MAX = 28'sd133546639;
	localparam logic signed [A1_W-1:0]   A1_MIN = -28'sd133546639;
	localparam logic signed [A2_W-1:0]   A2_MAX = 27'sd66437775;
	localparam logic signed [A2_W-1:0]   A2_MIN = -27'sd66437775;
	localparam logic [GAIN_W-1:0]        GAIN_MAX   = 16'd32768;
	localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LP_B0  = 3'd0,
		REG_HP_B0  = 3'd1,
		REG_A1     = 3'd2,
		REG_A2     = 3'd3,
		REG_GAIN   = 3'd4,
		REG_BYPASS = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] lp_b0;
		logic signed [COEF_W-1:0] hp_b0;
		logic signed [A1_W-1:0]   a1;
		logic signed [A2_W-1:0]   a2;
		logic [GAIN_W-1:0]        gain;
		logic                     bypass;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              mac;
		logic [SEC_W-1:0]  sec;
		logic [STEP_W-1:0] step;
		logic              mono_mul;
		logic              mono_fin;
		logic              out_load;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEC,
		ST_MONO_MUL,
		ST_MONO_FIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* src/sbm_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbm_cfg import sbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	logic signed [COEF_W-1:0] b0_w, b0_clamp;
	logic signed [A1_W-1:0]   a1_w, a1_clamp;
	logic signed [A2_W-1:0]   a2_w, a2_clamp;
	logic [GAIN_W-1:0]        gain_w, gain_clamp;

	// Clamp write data to each register's range
	always_comb begin
		b0_w   = $signed(wr_data[COEF_W-1:0]);
		a1_w   = $signed(wr_data[A1_W-1:0]);
		a2_w   = $signed(wr_data[A2_W-1:0]);
		gain_w = wr_data[GAIN_W-1:0];

		b0_clamp   = (b0_w > B0_MAX) ? B0_MAX : ((b0_w < B0_MIN) ? B0_MIN : b0_w);
		a1_clamp   = (a1_w > A1_MAX) ? A1_MAX : ((a1_w < A1_MIN) ? A1_MIN : a1_w);
		a2_clamp   = (a2_w > A2_MAX) ? A2_MAX : ((a2_w < A2_MIN) ? A2_MIN : a2_w);
		gain_clamp = (gain_w > GAIN_MAX) ? GAIN_MAX : gain_w;
	end

	// Decode the register index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lp_b0  <= '0;
			cfg_q.hp_b0  <= '0;
			cfg_q.a1     <= '0;
			cfg_q.a2     <= '0;
			cfg_q.gain   <= GAIN_RESET;
			cfg_q.bypass <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LP_B0:  cfg_q.lp_b0  <= b0_clamp;
				REG_HP_B0:  cfg_q.hp_b0  <= b0_clamp;
				REG_A1:     cfg_q.a1     <= a1_clamp;
				REG_A2:     cfg_q.a2     <= a2_clamp;
				REG_GAIN:   cfg_q.gain   <= gain_clamp;
				REG_BYPASS: cfg_q.bypass <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/sbm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbm_ctrl import sbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic bypass,
	output cmd_t cmd
);

	state_t            state_q, state_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              m_tvalid_q, m_tvalid_d;

	// Hold state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sec_q      <= '0;
			step_q     <= STEP_X0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sec_q      <= sec_d;
			step_q     <= step_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// Sequence eight sections, the mono gain, then the output transfer; bypass skips to the output transfer
	always_comb begin
		state_d    = state_q;
		sec_d      = sec_q;
		step_d     = step_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		s_tready   = 1'b0;
		cmd        = '0;
		cmd.sec    = sec_q;
		cmd.step   = step_q;

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					sec_d    = '0;
					step_d   = STEP_X0;
					state_d  = bypass ? ST_DONE : ST_SEC;
				end
			end
			ST_SEC: begin
				cmd.mac = 1'b1;
				if (step_q == STEP_FIN) begin
					step_d = STEP_X0;
					if (sec_q == SEC_LAST) begin
						state_d = ST_MONO_MUL;
					end else begin
						sec_d = sec_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_MONO_MUL: begin
				cmd.mono_mul = 1'b1;
				state_d      = ST_MONO_FIN;
			end
			ST_MONO_FIN: begin
				cmd.mono_fin = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

/* src/sbm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbm_dp import sbm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  cfg_t                           cfg,
	input  logic signed [SAMPLE_WIDTH-1:0] left_in,
	input  logic signed [SAMPLE_WIDTH-1:0] right_in,
	output logic signed [SAMPLE_WIDTH-1:0] left_out,
	output logic signed [SAMPLE_WIDTH-1:0] right_out
);

	localparam int MW    = (SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH;
	localparam int DW    = MW + 1;
	localparam int PW    = COEF_W + DW;
	localparam int ACC_W = PW + 3;
	localparam int YW    = ACC_W - COEF_FRAC;
	localparam int MON_W = PW + 1 - GAIN_SHIFT;
	localparam int OW    = ((STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH) + 1;

	localparam logic [ACC_W-1:0] ACC_ROUND =
		{{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
	localparam logic [PW:0] MONO_ROUND =
		{{(PW + 1 - GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT - 1){1'b0}}};

	// Captured item and band results
	logic signed [SAMPLE_WIDTH-1:0] samp_l_q, samp_r_q;
	logic                           byp_q;
	logic signed [STATE_WIDTH-1:0]  yprev_q, lo_l_q, lo_r_q, hi_l_q, hi_r_q, mono_q;
	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

	// Section delay lines
	logic signed [MW-1:0] xd1_q [NSEC];
	logic signed [MW-1:0] xd2_q [NSEC];
	logic signed [MW-1:0] yd1_q [NSEC];
	logic signed [MW-1:0] yd2_q [NSEC];

	// Shared multiplier and accumulator
	logic signed [COEF_W-1:0] coef_m, b0_w;
	logic signed [DW-1:0]     data_m;
	logic signed [MW-1:0]     x_w;
	logic signed [SAMPLE_WIDTH-1:0] samp_sel;
	logic                     hp, neg_d, dbl_d;
	logic signed [PW-1:0]     prod_s1;
	logic                     neg_s1, dbl_s1;
	logic signed [ACC_W-1:0]  acc_q, term_w, sum_w;

	logic signed [YW-1:0]          y_sh;
	logic [YW-STATE_WIDTH:0]       y_top;
	logic signed [STATE_WIDTH-1:0] y_sat;

	logic signed [PW:0]            m_sum;
	logic signed [MON_W-1:0]       m_sh;
	logic [MON_W-STATE_WIDTH:0]    m_top;
	logic signed [STATE_WIDTH-1:0] mono_sat;

	logic signed [OW-1:0]           ol_sum, or_sum;
	logic [OW-SAMPLE_WIDTH:0]       ol_top, or_top;
	logic signed [SAMPLE_WIDTH-1:0] ol_sat, or_sat;

	// Pick the section input and the product operands
	always_comb begin
		hp       = cmd.sec[1];
		samp_sel = cmd.sec[SEC_W-1] ? samp_r_q : samp_l_q;
		x_w      = cmd.sec[0] ? MW'(yprev_q) : MW'(samp_sel);
		b0_w     = hp ? cfg.hp_b0 : cfg.lp_b0;
		coef_m   = b0_w;
		data_m   = DW'(x_w);
		neg_d    = 1'b0;
		dbl_d    = 1'b0;
		if (cmd.mono_mul) begin
			coef_m = $signed({{(COEF_W - GAIN_W){1'b0}}, cfg.gain});
			data_m = DW'(lo_l_q) + DW'(lo_r_q);
		end else begin
			case (cmd.step)
				STEP_X1: begin
					data_m = DW'(xd1_q[cmd.sec]);
					dbl_d  = 1'b1;
					neg_d  = hp;
				end
				STEP_X2: begin
					data_m = DW'(xd2_q[cmd.sec]);
				end
				STEP_Y1: begin
					coef_m = COEF_W'(cfg.a1);
					data_m = DW'(yd1_q[cmd.sec]);
					neg_d  = 1'b1;
				end
				STEP_Y2: begin
					coef_m = COEF_W'(cfg.a2);
					data_m = DW'(yd2_q[cmd.sec]);
					neg_d  = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Register the product with its sign and doubling
	always_ff @(posedge clk) begin
		prod_s1 <= coef_m * data_m;
		neg_s1  <= neg_d;
		dbl_s1  <= dbl_d;
	end

	// Accumulate, then round and saturate the section output
	always_comb begin
		term_w = dbl_s1 ? (ACC_W'(prod_s1) <<< 1) : ACC_W'(prod_s1);
		sum_w  = neg_s1 ? (acc_q - term_w) : (acc_q + term_w);
		y_sh   = sum_w[ACC_W-1:COEF_FRAC];
		y_top  = y_sh[YW-1:STATE_WIDTH-1];
		y_sat  = ((y_top == '0) || (y_top == '1)) ? y_sh[STATE_WIDTH-1:0]
			: {y_sh[YW-1], {(STATE_WIDTH - 1){~y_sh[YW-1]}}};
	end

	// Round and saturate the mono low band
	always_comb begin
		m_sum    = $signed({prod_s1[PW-1], prod_s1}) + $signed(MONO_ROUND);
		m_sh     = m_sum[PW:GAIN_SHIFT];
		m_top    = m_sh[MON_W-1:STATE_WIDTH-1];
		mono_sat = ((m_top == '0) || (m_top == '1)) ? m_sh[STATE_WIDTH-1:0]
			: {m_sh[MON_W-1], {(STATE_WIDTH - 1){~m_sh[MON_W-1]}}};
	end

	// Add the high bands and saturate to the sample width
	always_comb begin
		ol_sum = OW'(mono_q) + OW'(hi_l_q);
		or_sum = OW'(mono_q) + OW'(hi_r_q);
		ol_top = ol_sum[OW-1:SAMPLE_WIDTH-1];
		or_top = or_sum[OW-1:SAMPLE_WIDTH-1];
		ol_sat = ((ol_top == '0) || (ol_top == '1)) ? ol_sum[SAMPLE_WIDTH-1:0]
			: {ol_sum[OW-1], {(SAMPLE_WIDTH - 1){~ol_sum[OW-1]}}};
		or_sat = ((or_top == '0) || (or_top == '1)) ? or_sum[SAMPLE_WIDTH-1:0]
			: {or_sum[OW-1], {(SAMPLE_WIDTH - 1){~or_sum[OW-1]}}};
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			samp_l_q <= left_in;
			samp_r_q <= right_in;
			byp_q    <= cfg.bypass;
		end
		if (cmd.mac) begin
			if (cmd.step == STEP_X0) begin
				acc_q <= ACC_ROUND;
			end else begin
				acc_q <= sum_w;
			end
			if (cmd.step == STEP_FIN) begin
				yprev_q <= y_sat;
				case (cmd.sec)
					SEC_LP2_L: lo_l_q <= y_sat;
					SEC_HP2_L: hi_l_q <= y_sat;
					SEC_LP2_R: lo_r_q <= y_sat;
					SEC_HP2_R: hi_r_q <= y_sat;
					default: ;
				endcase
			end
		end
		if (cmd.mono_fin) begin
			mono_q <= mono_sat;
		end
		if (cmd.out_load) begin
			left_q  <= byp_q ? samp_l_q : ol_sat;
			right_q <= byp_q ? samp_r_q : or_sat;
		end
	end

	// Advance the delay line of the finished section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSEC; i++) begin
				xd1_q[i] <= '0;
				xd2_q[i] <= '0;
				yd1_q[i] <= '0;
				yd2_q[i] <= '0;
			end
		end else if (cmd.mac && (cmd.step == STEP_FIN)) begin
			xd2_q[cmd.sec] <= xd1_q[cmd.sec];
			xd1_q[cmd.sec] <= x_w;
			yd2_q[cmd.sec] <= yd1_q[cmd.sec];
			yd1_q[cmd.sec] <= MW'(y_sat);
		end
	end

	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

`default_nettype wire

/* src/stereo_bass_mono_crossover.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: left_in, right_in
// m_        out        m_tvalid / m_tready    m_tdata: left_out, right_out
// wr_       in         wr_en                  wr_index, wr_data
//
// Each item runs from one input transfer to the next through these steps:
// eight biquad sections on the single shared multiplier, each as five
// products and a finish, the mono gain multiply and finish, the output register
// load in the done state, and the return to idle with ready high.
// With bypass set the controller goes from idle straight to the done state, which
// loads the output register once it is free; the next item follows in idle.
// Reset clears all section delays and loads the register reset values.
// A stalled output holds the result; the finished item waits in the done state.

module stereo_bass_mono_crossover import sbm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// left_in, right_in (lowest bits up)
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// left_out, right_out (lowest bits up)
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,
	input  logic                                    wr_en,
	input  logic [CFG_IDX_W-1:0]                    wr_index,
	input  logic [CFG_DATA_W-1:0]                   wr_data
);

	localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

	cfg_t cfg;
	cmd_t cmd;
	logic signed [SAMPLE_WIDTH-1:0] left_out, right_out;

	sbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.bypass   (cfg.bypass),
		.cmd      (cmd)
	);

	sbm_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.STATE_WIDTH  (STATE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.left_in   ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
		.right_in  ($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
		.left_out  (left_out),
		.right_out (right_out)
	);

	// Pack results, zero fill to whole bytes
	assign m_tdata = TDATA_W'({right_out, left_out});

	// One item at a time: ready drops after each input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Bypass with a free output register passes the samples through unchanged
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && cfg.bypass && !m_tvalid) |=> ##1
		(m_tvalid && (m_tdata[2*SAMPLE_WIDTH-1:0] == $past(s_tdata[2*SAMPLE_WIDTH-1:0], 2))))
		else $error("bypass result missing or altered");

	// A new result only appears at the end of an item's work
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the block was idle");

endmodule

`default_nettype wire
